>>> sv/mtk_pkg.sv
// Shared types, constants and code table for the ASCII to Morse keyer.
`timescale 1ns / 1ps
`default_nettype none

package mtk_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned UNITS_W  = 4;
    localparam int unsigned MS_W     = 12;
    localparam int unsigned UTIME_W  = 8;
    localparam int unsigned PAT_W    = 8;
    localparam int unsigned IDX_W    = 6;

    localparam logic [15:0]        SPACE_FLAG = 16'h8000;
    localparam logic [PAT_W-1:0]   MORE_MASK  = 8'hFE;
    localparam logic [IDX_W-1:0]   TABLE_TOP  = 6'd58;
    localparam logic [UTIME_W-1:0] UTIME_RST  = 8'd18;

    localparam logic [CHAR_W-1:0]  CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0]  CH_LOW_A   = 8'h61;
    localparam logic [CHAR_W-1:0]  CH_LOW_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0]  CASE_DIFF  = 8'h20;

    localparam logic [UNITS_W-1:0] U_DOT      = 4'd1;
    localparam logic [UNITS_W-1:0] U_DASH     = 4'd3;
    localparam logic [UNITS_W-1:0] U_ELEM_GAP = 4'd1;
    localparam logic [UNITS_W-1:0] U_CHAR_GAP = 4'd3;
    localparam logic [UNITS_W-1:0] U_WORD_GAP = 4'd7;
    localparam logic [UNITS_W-1:0] U_EOM_GAP  = 4'd10;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOM  = 1'b1;

    localparam logic [15:0] MORSE_TABLE [59] = '{
        16'h8000,
        16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
        16'd0, 16'd0, 16'd0, 16'd115, 16'd97, 16'd106, 16'd41,
        16'd63, 16'd62, 16'd60, 16'd56, 16'd48, 16'd32, 16'd33, 16'd35,
        16'd39, 16'd47, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd76,
        16'd0, 16'd6, 16'd17, 16'd21, 16'd9, 16'd2, 16'd20, 16'd11,
        16'd16, 16'd4, 16'd30, 16'd13, 16'd18, 16'd7, 16'd5, 16'd15,
        16'd22, 16'd27, 16'd10, 16'd8, 16'd3, 16'd12, 16'd24, 16'd14,
        16'd25, 16'd29, 16'd19
    };

    typedef struct packed {
        logic              command;
        logic [CHAR_W-1:0] character;
    } mtk_in_t;

    typedef struct packed {
        logic               tone_on;
        logic [UNITS_W-1:0] duration_units;
        logic [MS_W-1:0]    duration_ms;
        logic               last;
    } mtk_out_t;

    // one interval from the sequencer, before scaling to ms
    typedef struct packed {
        logic               valid;
        logic               tone_on;
        logic [UNITS_W-1:0] units;
        logic               last;
    } mtk_ivl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELEM,
        ST_ELEM_GAP,
        ST_CHAR_GAP,
        ST_WORD_GAP,
        ST_EOM_GAP
    } mtk_state_t;

    function automatic logic [15:0] table_lookup(input logic [IDX_W-1:0] idx);
        logic [15:0] v;
        v = 16'd0;
        if (idx <= TABLE_TOP)
        begin
            v = MORSE_TABLE[idx];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> sv/mtk_seq.sv
// Interval sequencer: table lookup and pattern shift, one interval per cycle while busy.
`timescale 1ns / 1ps
`default_nettype none

module mtk_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire mtk_pkg::mtk_in_t request,
    output logic                 busy,
    output mtk_pkg::mtk_ivl_t    ivl
);

    mtk_pkg::mtk_state_t              state_reg, state_next;
    logic [mtk_pkg::PAT_W-1:0]        pat_reg, pat_next;
    logic [mtk_pkg::CHAR_W-1:0]       ch_fold;
    logic [mtk_pkg::CHAR_W-1:0]       ch_off;
    logic                             in_range;
    logic [15:0]                      entry;
    logic [mtk_pkg::PAT_W-1:0]        pat_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtk_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
    end

    always_comb
    begin
        ch_fold = request.character;
        if (request.character >= mtk_pkg::CH_LOW_A && request.character <= mtk_pkg::CH_LOW_Z)
        begin
            ch_fold = request.character - mtk_pkg::CASE_DIFF;
        end
        ch_off    = ch_fold - mtk_pkg::CH_SPACE;
        in_range  = (ch_fold >= mtk_pkg::CH_SPACE) &&
                    (ch_off <= mtk_pkg::CHAR_W'(mtk_pkg::TABLE_TOP));
        entry     = mtk_pkg::table_lookup(ch_off[mtk_pkg::IDX_W-1:0]);
        pat_shift = pat_reg >> 1;
    end

    always_comb
    begin
        state_next  = state_reg;
        pat_next    = pat_reg;
        ivl         = '0;
        busy        = (state_reg != mtk_pkg::ST_IDLE);
        unique case (state_reg)
            mtk_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (request.command == mtk_pkg::CMD_EOM)
                    begin
                        state_next = mtk_pkg::ST_EOM_GAP;
                    end
                    else if (in_range)
                    begin
                        pat_next = entry[mtk_pkg::PAT_W-1:0];
                        if ((entry & mtk_pkg::SPACE_FLAG) != 16'd0)
                        begin
                            state_next = mtk_pkg::ST_WORD_GAP;
                        end
                        else if ((entry[mtk_pkg::PAT_W-1:0] & mtk_pkg::MORE_MASK) != '0)
                        begin
                            state_next = mtk_pkg::ST_ELEM;
                        end
                        else
                        begin
                            state_next = mtk_pkg::ST_CHAR_GAP;
                        end
                    end
                end
            end
            mtk_pkg::ST_ELEM:
            begin
                ivl.valid   = 1'b1;
                ivl.tone_on = 1'b1;
                ivl.units   = pat_reg[0] ? mtk_pkg::U_DASH : mtk_pkg::U_DOT;
                state_next  = mtk_pkg::ST_ELEM_GAP;
            end
            mtk_pkg::ST_ELEM_GAP:
            begin
                ivl.valid = 1'b1;
                ivl.units = mtk_pkg::U_ELEM_GAP;
                pat_next  = pat_shift;
                if ((pat_shift & mtk_pkg::MORE_MASK) != '0)
                begin
                    state_next = mtk_pkg::ST_ELEM;
                end
                else
                begin
                    state_next = mtk_pkg::ST_CHAR_GAP;
                end
            end
            mtk_pkg::ST_CHAR_GAP:
            begin
                ivl.valid  = 1'b1;
                ivl.units  = mtk_pkg::U_CHAR_GAP;
                ivl.last   = 1'b1;
                state_next = mtk_pkg::ST_IDLE;
            end
            mtk_pkg::ST_WORD_GAP:
            begin
                ivl.valid  = 1'b1;
                ivl.units  = mtk_pkg::U_WORD_GAP;
                ivl.last   = 1'b1;
                state_next = mtk_pkg::ST_IDLE;
            end
            mtk_pkg::ST_EOM_GAP:
            begin
                ivl.valid  = 1'b1;
                ivl.units  = mtk_pkg::U_EOM_GAP;
                ivl.last   = 1'b1;
                state_next = mtk_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mtk_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/ascii_to_morse_keyer.sv
// Top level of the ASCII to Morse keyer: unit time register and result stage.
//
// Usage:
//   Drive request (command, character) and pulse start while busy is low; the
//   word is taken at that edge. command = 1 asks for the end-of-message gap.
//   Each resulting interval appears on result for one cycle with strobe high;
//   result.last marks the final interval of the word. The receiver cannot
//   stall, so every result must be taken in the cycle it is shown.
//   The state register of the sequencer and the result register lie between
//   the accepting edge and the first result on the ports.
//   Throughput: one interval per cycle from the sequencer while busy; busy stays
//   high through every element and gap of a letter with a code, and through the
//   single gap for space, an entry without a code or end of message. A new word
//   is taken only once busy is low again. Characters outside space..'Z' after case
//   folding give no result and keep busy low.
//   duration_ms is units times unit_time_ms, formed in the result stage.
//   cfg_we writes unit_time_ms from cfg_data; write only while idle.
//   Reset: sequencer idle, no strobe, unit_time_ms = 18.
`timescale 1ns / 1ps
`default_nettype none

module ascii_to_morse_keyer (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire mtk_pkg::mtk_in_t             request,
    output logic                              busy,
    output logic                              strobe,
    output mtk_pkg::mtk_out_t                 result,
    input  wire logic                         cfg_we,
    input  wire logic [mtk_pkg::UTIME_W-1:0]  cfg_data
);

    logic [mtk_pkg::UTIME_W-1:0] utime_reg;
    logic                        strobe_reg;
    mtk_pkg::mtk_out_t           result_reg, result_next;
    mtk_pkg::mtk_ivl_t           ivl;

    mtk_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .ivl     (ivl)
    );

    always_comb
    begin
        result_next.tone_on        = ivl.tone_on;
        result_next.duration_units = ivl.units;
        result_next.duration_ms    = mtk_pkg::MS_W'(ivl.units) * mtk_pkg::MS_W'(utime_reg);
        result_next.last           = ivl.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utime_reg  <= mtk_pkg::UTIME_RST;
            strobe_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                utime_reg <= cfg_data;
            end
            strobe_reg <= ivl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> tb/morse_interval_checker.sv
// Checker for the Morse keyer: predicts the intervals of each word and compares the results.
`timescale 1ns / 1ps

module morse_interval_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  mtk_pkg::mtk_in_t            request,
    input  logic                        busy,
    input  logic                        strobe,
    input  mtk_pkg::mtk_out_t           result,
    input  logic                        cfg_we,
    input  logic [mtk_pkg::UTIME_W-1:0] cfg_data,
    output int                          pending,
    output int                          fail_count
);

    logic [mtk_pkg::UTIME_W-1:0] unit_ms;
    mtk_pkg::mtk_out_t           intervals_due[$];

    function automatic mtk_pkg::mtk_out_t interval(input logic tone,
                                                   input logic [mtk_pkg::UNITS_W-1:0] units);
        mtk_pkg::mtk_out_t ivl;
        int unsigned       ms;
        ms                 = 32'(units) * 32'(unit_ms);
        ivl.tone_on        = tone;
        ivl.duration_units = units;
        ivl.duration_ms    = ms[mtk_pkg::MS_W-1:0];
        ivl.last           = 1'b0;
        return ivl;
    endfunction

    // Expected intervals of one accepted word; out of range characters key nothing.
    task automatic key_word(input mtk_pkg::mtk_in_t w);
        logic [mtk_pkg::CHAR_W-1:0] ch;
        logic [mtk_pkg::IDX_W-1:0]  idx;
        logic [15:0]                entry;
        logic [mtk_pkg::PAT_W-1:0]  pat;
        mtk_pkg::mtk_out_t          seq[$];
        if (w.command == mtk_pkg::CMD_EOM)
        begin
            seq.push_back(interval(1'b0, mtk_pkg::U_EOM_GAP));
        end
        else
        begin
            ch = w.character;
            if (ch >= mtk_pkg::CH_LOW_A && ch <= mtk_pkg::CH_LOW_Z)
            begin
                ch = ch - mtk_pkg::CASE_DIFF;
            end
            if (ch < mtk_pkg::CH_SPACE ||
                ch - mtk_pkg::CH_SPACE > mtk_pkg::CHAR_W'(mtk_pkg::TABLE_TOP))
            begin
                return;
            end
            idx   = mtk_pkg::IDX_W'(ch - mtk_pkg::CH_SPACE);
            entry = mtk_pkg::MORSE_TABLE[idx];
            if ((entry & mtk_pkg::SPACE_FLAG) != 16'd0)
            begin
                seq.push_back(interval(1'b0, mtk_pkg::U_WORD_GAP));
            end
            else
            begin
                pat = entry[mtk_pkg::PAT_W-1:0];
                while ((pat & mtk_pkg::MORE_MASK) != '0 && seq.size() < 12)
                begin
                    seq.push_back(interval(1'b1, pat[0] ? mtk_pkg::U_DASH : mtk_pkg::U_DOT));
                    seq.push_back(interval(1'b0, mtk_pkg::U_ELEM_GAP));
                    pat = pat >> 1;
                end
                seq.push_back(interval(1'b0, mtk_pkg::U_CHAR_GAP));
            end
        end
        seq[seq.size()-1].last = 1'b1;
        foreach (seq[i])
        begin
            intervals_due.push_back(seq[i]);
        end
    endtask

    function automatic logic field_differs(input string name, input int unsigned want,
                                           input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
        return want != got;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mtk_pkg::mtk_out_t want;
        logic              bad;
        if (!rst_n)
        begin
            unit_ms    = mtk_pkg::UTIME_RST;
            fail_count = 0;
            intervals_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                unit_ms = cfg_data;
            end
            if (strobe)
            begin
                if (intervals_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %h", $time, result);
                    fail_count++;
                end
                else
                begin
                    want = intervals_due.pop_front();
                    bad  = 1'b0;
                    bad |= field_differs("tone_on", 32'(want.tone_on), 32'(result.tone_on));
                    bad |= field_differs("duration_units", 32'(want.duration_units),
                                         32'(result.duration_units));
                    bad |= field_differs("duration_ms", 32'(want.duration_ms),
                                         32'(result.duration_ms));
                    bad |= field_differs("last", 32'(want.last), 32'(result.last));
                    if (bad)
                    begin
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                key_word(request);
            end
        end
        pending <= intervals_due.size();
    end

endmodule

>>> tb/ascii_to_morse_keyer_tb.sv
// Testbench top for the Morse keyer: reset, clock, word and unit time stimulus, verdict.
`timescale 1ns / 1ps

module ascii_to_morse_keyer_tb;

    logic                        clk      = 1'b0;
    logic                        rst_n    = 1'b0;
    logic                        start    = 1'b0;
    mtk_pkg::mtk_in_t            request  = '0;
    logic                        cfg_we   = 1'b0;
    logic [mtk_pkg::UTIME_W-1:0] cfg_data = '0;
    logic                        busy;
    logic                        strobe;
    mtk_pkg::mtk_out_t           result;
    int                          pending;
    int                          fail_count;

    always #10 clk = ~clk;

    ascii_to_morse_keyer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .strobe   (strobe),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    morse_interval_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .request    (request),
        .busy       (busy),
        .strobe     (strobe),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // space, letters both cases, digits, hyphen, punctuation, empty patterns,
    // bytes just outside the table, end of message
    mtk_pkg::mtk_in_t directed_words [24] = '{
        '{mtk_pkg::CMD_CHAR, 8'h20}, '{mtk_pkg::CMD_CHAR, 8'h41}, '{mtk_pkg::CMD_CHAR, 8'h5A},
        '{mtk_pkg::CMD_CHAR, 8'h61}, '{mtk_pkg::CMD_CHAR, 8'h7A}, '{mtk_pkg::CMD_CHAR, 8'h30},
        '{mtk_pkg::CMD_CHAR, 8'h39}, '{mtk_pkg::CMD_CHAR, 8'h2D}, '{mtk_pkg::CMD_CHAR, 8'h2C},
        '{mtk_pkg::CMD_CHAR, 8'h2E}, '{mtk_pkg::CMD_CHAR, 8'h3F}, '{mtk_pkg::CMD_CHAR, 8'h21},
        '{mtk_pkg::CMD_CHAR, 8'h40}, '{mtk_pkg::CMD_CHAR, 8'h45}, '{mtk_pkg::CMD_CHAR, 8'h54},
        '{mtk_pkg::CMD_CHAR, 8'h1F}, '{mtk_pkg::CMD_CHAR, 8'h5B}, '{mtk_pkg::CMD_CHAR, 8'h60},
        '{mtk_pkg::CMD_CHAR, 8'h7B}, '{mtk_pkg::CMD_CHAR, 8'h00}, '{mtk_pkg::CMD_CHAR, 8'hFF},
        '{mtk_pkg::CMD_EOM,  8'h00}, '{mtk_pkg::CMD_EOM,  8'hFF}, '{mtk_pkg::CMD_CHAR, 8'h4D}
    };

    int unsigned phase_idle_pct [4] = '{21, 51, 0, 0};
    int unsigned phase_words    [4] = '{120, 120, 50, 100};

    task automatic send_word(input mtk_pkg::mtk_in_t w, input int unsigned gap);
        request <= w;
        start   <= 1'b1;
        do @(posedge clk); while (busy);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off until every expected interval is out, then let the pipeline settle.
    task automatic wait_keyer_idle();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_unit_time(input logic [mtk_pkg::UTIME_W-1:0] v);
        wait_keyer_idle();
        cfg_data <= v;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic mtk_pkg::mtk_in_t random_word();
        mtk_pkg::mtk_in_t w;
        int unsigned      r;
        r           = $urandom_range(0, 99);
        w.command   = mtk_pkg::CMD_CHAR;
        w.character = mtk_pkg::CHAR_W'($urandom);
        if (r < 10)
        begin
            w.command = mtk_pkg::CMD_EOM;
        end
        else if (r < 50)
        begin
            w.character = mtk_pkg::CHAR_W'($urandom_range(32'(mtk_pkg::CH_SPACE),
                              32'(mtk_pkg::CH_SPACE) + 32'(mtk_pkg::TABLE_TOP)));
        end
        else if (r < 80)
        begin
            w.character = mtk_pkg::CHAR_W'($urandom_range(32'(mtk_pkg::CH_LOW_A),
                                                          32'(mtk_pkg::CH_LOW_Z)));
        end
        return w;
    endfunction

    initial
    begin
        mtk_pkg::mtk_in_t            w;
        int unsigned                 keyed;
        int unsigned                 gap;
        logic [mtk_pkg::UTIME_W-1:0] unit_values [4];
        unit_values = '{8'd1, 8'd255, 8'd0, 8'($urandom_range(2, 254))};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_words[i])
        begin
            send_word(directed_words[i], $urandom_range(0, 2));
        end

        foreach (unit_values[p])
        begin
            set_unit_time(unit_values[p]);
            keyed = 0;
            while (keyed < phase_words[p])
            begin
                w   = random_word();
                gap = ($urandom_range(0, 99) < phase_idle_pct[p]) ? $urandom_range(1, 6) : 0;
                if (w.command == mtk_pkg::CMD_EOM ||
                    (w.character >= mtk_pkg::CH_SPACE &&
                     w.character <= mtk_pkg::CH_SPACE + mtk_pkg::CHAR_W'(mtk_pkg::TABLE_TOP)) ||
                    (w.character >= mtk_pkg::CH_LOW_A && w.character <= mtk_pkg::CH_LOW_Z))
                begin
                    keyed++;
                end
                send_word(w, gap);
            end
        end

        wait_keyer_idle();
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
sv/mtk_pkg.sv
sv/mtk_seq.sv
sv/ascii_to_morse_keyer.sv
tb/morse_interval_checker.sv
tb/ascii_to_morse_keyer_tb.sv
